// File: hw/rtl/hpp_pkg.sv
// ----------------------------------------------------------------------------
// hpp_pkg
// Types, constants and codes shared by the header parser modules.
// ----------------------------------------------------------------------------
package hpp_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int VERSION_W  = 32;
    localparam int CODE_W     = 24;
    localparam int BODY_LEN_W = 17;
    localparam int HDR_LEN_W  = 16;
    localparam int COUNT_W    = 3;

    localparam int RESULT_W   = STATUS_W + VERSION_W + CODE_W + BODY_LEN_W + HDR_LEN_W;
    localparam int TDATA_O_W  = ((RESULT_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0]     SEP_CHAR   = 8'h7C;
    localparam logic [BYTE_W-1:0]     DIGIT_LO   = 8'h30;
    localparam logic [BYTE_W-1:0]     DIGIT_HI   = 8'h39;
    localparam logic [COUNT_W-1:0]    CODE_BYTES = 3'd3;
    localparam logic [COUNT_W-1:0]    LEN_DIGITS = 3'd5;
    localparam logic [COUNT_W-1:0]    COUNT_SAT  = 3'd7;
    localparam logic [HDR_LEN_W-1:0]  BYTES_SAT  = 16'hFFFF;
    localparam logic [BODY_LEN_W-1:0] MAX_LEN_RESET = 17'd99999;
    localparam logic [HDR_LEN_W-1:0]  MIN_HDR_LEN   = 16'd8;

    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED     = 2'd3;

    typedef enum logic [4:0] {
        PH_VERSION = 5'b00001,
        PH_CODE    = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_DONE    = 5'b01000,
        PH_BAD     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start;
    } t_in_item;

    typedef struct packed {
        logic [HDR_LEN_W-1:0]  header_length;
        logic [BODY_LEN_W-1:0] body_length;
        logic [CODE_W-1:0]     message_code;
        logic [VERSION_W-1:0]  version;
        logic [STATUS_W-1:0]   status;
    } t_result;

    typedef struct packed {
        t_phase                phase;
        logic [VERSION_W-1:0]  ver_acc;
        logic [CODE_W-1:0]     code;
        logic [BODY_LEN_W-1:0] len_acc;
        logic [COUNT_W-1:0]    count;
        logic                  err;
        logic [HDR_LEN_W-1:0]  bytes_seen;
    } t_parse_state;

    localparam t_parse_state CLEAR_STATE = '{
        phase:      PH_VERSION,
        ver_acc:    '0,
        code:       '0,
        len_acc:    '0,
        count:      '0,
        err:        1'b0,
        bytes_seen: '0
    };

endpackage

// File: hw/rtl/pipe_delimited_header_parser_core.sv
// ----------------------------------------------------------------------------
// pipe_delimited_header_parser_core
// Path: a byte accepted into the input register is parsed and its status is
// loaded into the result register on the master side.
// Throughput: one byte per cycle while the master side takes results; the parser state update is a single step.
// A stalled master side holds the result register and back-pressures input.
// Reset (synchronous, active low) clears the parse state and sets the
// maximum body length to 99999; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pipe_delimited_header_parser_core
    import hpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // data_byte
    input  logic                  s_axis_tuser,   // start_of_header
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, version, message_code, body_length, header_length, zero pad
    output logic [TDATA_O_W-1:0]  m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [BODY_LEN_W-1:0] i_cfg_data      // max_body_length
);

    logic [BODY_LEN_W-1:0] r_max_len;
    t_in_item              in_item;
    t_in_item              stage_item;
    logic                  stage_valid;
    logic                  load_ready;
    logic                  advance;
    t_result               step_result;
    t_result               out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.start     = s_axis_tuser;
    assign advance           = stage_valid && load_ready;

    hpp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    hpp_parse_core u_parse_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (stage_item),
        .i_max_len (r_max_len),
        .o_result  (step_result)
    );

    hpp_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance),
        .i_result     (step_result),
        .o_load_ready (load_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (out_result)
    );

    assign m_axis_tdata = {{(TDATA_O_W-RESULT_W){1'b0}}, out_result};

endmodule

// File: hw/rtl/hpp_in_stage.sv
// ----------------------------------------------------------------------------
// hpp_in_stage
// Input register for header bytes; holds one item until the parser takes it.
// ----------------------------------------------------------------------------
module hpp_in_stage
    import hpp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hw/rtl/hpp_parse_core.sv
// ----------------------------------------------------------------------------
// hpp_parse_core
// Parser state and the per-byte update: field accumulation, separator checks
// and the status for the prefix seen so far.
// ----------------------------------------------------------------------------
module hpp_parse_core
    import hpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  t_in_item              i_item,
    input  logic [BODY_LEN_W-1:0] i_max_len,
    output t_result               o_result
);

    t_parse_state r_st;
    t_parse_state n_st;

    always_comb begin
        t_parse_state     cur;
        logic             is_sep;
        logic             is_digit;
        logic             bad;
        t_phase           nxt_phase;
        logic [3:0]       digit;
        logic [VERSION_W+3:0]  ver_next;
        logic [BODY_LEN_W+3:0] len_next;
        logic [BYTE_W-1:0] b;

        b   = i_item.data_byte;
        cur = i_item.start ? CLEAR_STATE : r_st;
        n_st = cur;

        is_sep   = (b == SEP_CHAR);
        is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
        digit    = b[3:0];
        ver_next = ({4'b0, cur.ver_acc} << 3) + ({4'b0, cur.ver_acc} << 1)
                 + {{VERSION_W{1'b0}}, digit};
        len_next = ({4'b0, cur.len_acc} << 3) + ({4'b0, cur.len_acc} << 1)
                 + {{BODY_LEN_W{1'b0}}, digit};
        bad       = 1'b0;
        nxt_phase = PH_BAD;

        if (cur.phase == PH_VERSION || cur.phase == PH_CODE || cur.phase == PH_LENGTH) begin
            if (cur.bytes_seen != BYTES_SAT) begin
                n_st.bytes_seen = cur.bytes_seen + 16'd1;
            end
            if (is_sep) begin
                case (cur.phase)
                    PH_VERSION: begin
                        bad       = (cur.count == '0);
                        nxt_phase = PH_CODE;
                    end
                    PH_CODE: begin
                        bad       = (cur.count != CODE_BYTES);
                        nxt_phase = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        bad       = (cur.count == '0) || (cur.count > LEN_DIGITS);
                        nxt_phase = PH_DONE;
                    end
                    default: begin
                        bad       = 1'b1;
                        nxt_phase = PH_BAD;
                    end
                endcase
                n_st.phase = (bad || cur.err) ? PH_BAD : nxt_phase;
                n_st.count = '0;
                n_st.err   = 1'b0;
            end else begin
                case (cur.phase)
                    PH_VERSION: begin
                        if (!is_digit) begin
                            n_st.err = 1'b1;
                        end else if (!cur.err) begin
                            if (ver_next[VERSION_W+3:VERSION_W] != 4'd0) begin
                                n_st.err = 1'b1;
                            end else begin
                                n_st.ver_acc = ver_next[VERSION_W-1:0];
                            end
                        end
                    end
                    PH_CODE: begin
                        if (cur.count < CODE_BYTES) begin
                            n_st.code = {cur.code[CODE_W-BYTE_W-1:0], b};
                        end
                    end
                    PH_LENGTH: begin
                        if (!is_digit) begin
                            n_st.err = 1'b1;
                        end else if (!cur.err) begin
                            if (len_next > {4'b0, i_max_len}) begin
                                n_st.err = 1'b1;
                            end else begin
                                n_st.len_acc = len_next[BODY_LEN_W-1:0];
                            end
                        end
                    end
                    default: begin
                        n_st.err = cur.err;
                    end
                endcase
                if (cur.count != COUNT_SAT) begin
                    n_st.count = cur.count + 3'd1;
                end
            end
        end

        if (n_st.phase == PH_DONE) begin
            o_result.status        = ST_COMPLETE;
            o_result.version       = n_st.ver_acc;
            o_result.message_code  = n_st.code;
            o_result.body_length   = n_st.len_acc;
            o_result.header_length = n_st.bytes_seen;
        end else begin
            o_result.status        = (n_st.phase == PH_BAD) ? ST_INVALID : ST_INCOMPLETE;
            o_result.version       = '0;
            o_result.message_code  = '0;
            o_result.body_length   = '0;
            o_result.header_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= CLEAR_STATE;
        end else if (i_advance) begin
            r_st <= n_st;
        end
    end

endmodule

// File: hw/rtl/hpp_out_stage.sv
// ----------------------------------------------------------------------------
// hpp_out_stage
// Result register on the master side; loads a new result when empty or while
// the old one is being taken.
// ----------------------------------------------------------------------------
module hpp_out_stage
    import hpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_load_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_load_ready = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_result     = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hw/rtl/hpp_checker.sv
// ----------------------------------------------------------------------------
// hpp_checker
// Port-level checks on the header parser result stream.
// ----------------------------------------------------------------------------
module hpp_checker
    import hpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [TDATA_O_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0]  status;
    logic [HDR_LEN_W-1:0] hdr_len;

    assign status  = m_axis_tdata[STATUS_W-1:0];
    assign hdr_len = m_axis_tdata[RESULT_W-1:RESULT_W-HDR_LEN_W];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> status != ST_UNUSED)
        else $error("unused status code");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != ST_COMPLETE |-> m_axis_tdata[TDATA_O_W-1:STATUS_W] == '0)
        else $error("fields nonzero without complete status");

    a_min_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_COMPLETE |-> hdr_len >= MIN_HDR_LEN)
        else $error("complete header shorter than minimum");

endmodule

bind pipe_delimited_header_parser_core hpp_checker u_hpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/header_status_checker.sv
// ----------------------------------------------------------------------------
// header_status_checker
// Watches the byte, result and limit channels of the header parser, keeps
// its own copy of the parse state and compares every result item field by
// field with the status predicted for the matching input byte.
// ----------------------------------------------------------------------------
module header_status_checker
    import hpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_valid,
    input  logic                  i_byte_ready,
    input  logic [BYTE_W-1:0]     i_byte,
    input  logic                  i_start,
    input  logic                  i_report_valid,
    input  logic                  i_report_ready,
    input  logic [TDATA_O_W-1:0]  i_report_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [BODY_LEN_W-1:0] i_cfg_data,
    output int                    o_waiting,
    output int                    o_fail_count,
    output int                    o_checked,
    output int                    o_complete,
    output int                    o_invalid
);
    timeunit 1ns;
    timeprecision 1ps;

    t_phase                phase;
    logic [VERSION_W-1:0]  ver_acc;
    logic [CODE_W-1:0]     code;
    logic [BODY_LEN_W-1:0] len_acc;
    logic [COUNT_W-1:0]    fld_cnt;
    logic                  fld_err;
    logic [HDR_LEN_W-1:0]  hdr_bytes;
    logic [BODY_LEN_W-1:0] max_len;
    t_result               report_q[$];
    int                    fails;
    int                    checked;
    int                    n_complete;
    int                    n_invalid;

    assign o_fail_count = fails;
    assign o_checked    = checked;
    assign o_complete   = n_complete;
    assign o_invalid    = n_invalid;

    function void clear_parser();
        phase     = PH_VERSION;
        ver_acc   = '0;
        code      = '0;
        len_acc   = '0;
        fld_cnt   = '0;
        fld_err   = 1'b0;
        hdr_bytes = '0;
    endfunction

    function logic [31:0] take_digit(input logic [31:0] acc, input logic [7:0] b,
                                     input logic [32:0] limit);
        logic [35:0] nxt;
        if (b < DIGIT_LO || b > DIGIT_HI) begin
            fld_err = 1'b1;
            return acc;
        end
        if (fld_err)
            return acc;
        nxt = {4'd0, acc} * 36'd10 + {28'd0, b - DIGIT_LO};
        if (nxt > {3'd0, limit}) begin
            fld_err = 1'b1;
            return acc;
        end
        return nxt[31:0];
    endfunction

    function void close_field(input t_phase nxt, input logic bad);
        phase   = (bad || fld_err) ? PH_BAD : nxt;
        fld_cnt = '0;
        fld_err = 1'b0;
    endfunction

    function t_result parse_byte(input logic [7:0] b, input logic st);
        t_result     r;
        logic [31:0] tmp;
        if (st)
            clear_parser();
        if (phase != PH_DONE && phase != PH_BAD) begin
            if (hdr_bytes != BYTES_SAT)
                hdr_bytes = hdr_bytes + 16'd1;
            if (b == SEP_CHAR) begin
                case (phase)
                    PH_VERSION: close_field(PH_CODE, fld_cnt == 0);
                    PH_CODE:    close_field(PH_LENGTH, fld_cnt != CODE_BYTES);
                    default:    close_field(PH_DONE, fld_cnt == 0 || fld_cnt > LEN_DIGITS);
                endcase
            end else begin
                case (phase)
                    PH_VERSION: ver_acc = take_digit(ver_acc, b, 33'hFFFF_FFFF);
                    PH_CODE: begin
                        if (fld_cnt < CODE_BYTES)
                            code = {code[15:0], b};
                    end
                    default: begin
                        tmp     = take_digit({15'd0, len_acc}, b, {16'd0, max_len});
                        len_acc = tmp[BODY_LEN_W-1:0];
                    end
                endcase
                if (fld_cnt != COUNT_SAT)
                    fld_cnt = fld_cnt + 3'd1;
            end
        end
        r = '0;
        if (phase == PH_DONE) begin
            r.status        = ST_COMPLETE;
            r.version       = ver_acc;
            r.message_code  = code;
            r.body_length   = len_acc;
            r.header_length = hdr_bytes;
        end else begin
            r.status = (phase == PH_BAD) ? ST_INVALID : ST_INCOMPLETE;
        end
        return r;
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_parser();
            max_len = MAX_LEN_RESET;
            report_q.delete();
            o_waiting <= 0;
        end else begin
            if (i_report_valid && i_report_ready) begin
                got = t_result'(i_report_data[RESULT_W-1:0]);
                if (report_q.size() == 0) begin
                    $error("result item with no byte pending: status %0d", got.status);
                    fails++;
                end else begin
                    want = report_q.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("version", want.version, got.version);
                    check_field("message_code", 32'(want.message_code),
                                32'(got.message_code));
                    check_field("body_length", 32'(want.body_length),
                                32'(got.body_length));
                    check_field("header_length", 32'(want.header_length),
                                32'(got.header_length));
                    checked++;
                    if (want.status == ST_COMPLETE)
                        n_complete++;
                    if (want.status == ST_INVALID)
                        n_invalid++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                max_len = i_cfg_data;
            if (i_byte_valid && i_byte_ready)
                report_q.push_back(parse_byte(i_byte, i_start));
            o_waiting <= report_q.size();
        end
    end

endmodule

// File: dv/pipe_delimited_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// pipe_delimited_header_parser_core_tb
// Feeds the parser directed and random headers with random gaps and stalls,
// changes the body length limit between phases and lets the checker compare
// every status item.
// ----------------------------------------------------------------------------
module pipe_delimited_header_parser_core_tb;
    import hpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS    = 1200;
    localparam int PHASES   = 7;
    localparam int LIMIT    = 2_000_000;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [BYTE_W-1:0]     s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [BODY_LEN_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [TDATA_O_W-1:0]  m_tdata;
    logic                  cfg_ready;

    int                    waiting;
    int                    fail_count;
    int                    checked;
    int                    n_complete;
    int                    n_invalid;
    int                    sent;
    int                    cycles;
    int                    cfg_writes;
    bit                    tx_burst;
    bit                    rx_burst;
    logic [BYTE_W-1:0]     hdr_q[$];
    logic [BODY_LEN_W-1:0] max_len_tb = MAX_LEN_RESET;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) cycles <= cycles + 1;

    pipe_delimited_header_parser_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    header_status_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (s_tvalid),
        .i_byte_ready   (s_tready),
        .i_byte         (s_tdata),
        .i_start        (s_tuser),
        .i_report_valid (m_tvalid),
        .i_report_ready (m_tready),
        .i_report_data  (m_tdata),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_waiting      (waiting),
        .o_fail_count   (fail_count),
        .o_checked      (checked),
        .o_complete     (n_complete),
        .o_invalid      (n_invalid)
    );

    // result side stalls
    initial begin : rx_side
        int gap;
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    initial begin
        while (cycles < LIMIT) @(posedge i_clk);
        $display("pipe_delimited_header_parser_core test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    task automatic send_text(input string s, input logic st);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], (i == 0) ? st : 1'b0);
    endtask

    // a start flag now and then lands inside a header
    task automatic send_queue(input logic first_start, input int keep);
        for (int i = 0; i < hdr_q.size() && i < keep; i++)
            send_byte(hdr_q[i], (i == 0) ? first_start : ($urandom_range(0, 99) == 0));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [BODY_LEN_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len_tb = v;
        cfg_writes++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == SEP_CHAR);
        return b;
    endfunction

    function automatic void push_decimal(input longint unsigned v, input int min_digits);
        logic [7:0] digs[$];
        logic [7:0] d;
        do begin
            d = 8'(v % 10);
            digs.push_front(DIGIT_LO + d);
            v = v / 10;
        end while (v != 0 || digs.size() < min_digits);
        foreach (digs[i])
            hdr_q.push_back(digs[i]);
    endfunction

    function automatic void build_header();
        int               k;
        longint unsigned  v;
        int               lim;
        hdr_q.delete();
        lim = (max_len_tb > 99999) ? 99999 : max_len_tb;
        k = $urandom_range(0, 19);
        case (k)
            0: ;
            1: push_decimal(64'hFFFF_FFFF, 0);
            2: push_decimal(64'h1_0000_0000, 0);
            3: begin
                v = (longint'($urandom_range(0, 3)) << 32) | $urandom;
                push_decimal(v, 0);
            end
            4: push_decimal($urandom_range(0, 999), $urandom_range(4, 12));
            default: push_decimal($urandom_range(0, 1) ? $urandom : $urandom_range(0, 99), 0);
        endcase
        if ($urandom_range(0, 15) == 0)
            hdr_q.push_back(plain_byte());
        hdr_q.push_back(SEP_CHAR);
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 3;
        repeat (k) hdr_q.push_back(plain_byte());
        hdr_q.push_back(SEP_CHAR);
        k = $urandom_range(0, 19);
        case (k)
            0: ;
            1: push_decimal($urandom_range(0, 99), $urandom_range(6, 7));
            2: push_decimal(max_len_tb, 0);
            3: push_decimal(max_len_tb + 1, 0);
            4: push_decimal($urandom_range(0, 9), $urandom_range(2, 5));
            default: push_decimal($urandom_range(0, lim), 0);
        endcase
        if ($urandom_range(0, 15) == 0)
            hdr_q.push_back(plain_byte());
        hdr_q.push_back(SEP_CHAR);
        repeat ($urandom_range(0, 2)) hdr_q.push_back(8'($urandom));
    endfunction

    initial begin : stimulus
        logic [BODY_LEN_W-1:0] limits[PHASES];
        int                    kind;
        limits = '{17'd0, 17'd9, 17'd10, 17'h1FFFF, 17'd0, 17'd1, MAX_LEN_RESET};
        limits[4] = 17'($urandom_range(11, 99998));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // header with no start since reset, then ignored byte
        send_text("7|abc|9|", 1'b0);
        send_text("Z", 1'b0);
        // empty version field
        send_text("|", 1'b1);
        send_text("5", 1'b0);
        // extreme code bytes, empty length field
        hdr_q = '{"0", "|", 8'h00, 8'hFF, 8'h7B, "|", "|"};
        send_queue(1'b1, hdr_q.size());
        // short code field
        send_text("9|ab|", 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            write_max_len(limits[p]);
            while (sent < 25 + (p + 1) * ITEMS / PHASES) begin
                tx_burst = ($urandom_range(0, 7) == 0);
                rx_burst = ($urandom_range(0, 7) == 0);
                build_header();
                kind = $urandom_range(0, 9);
                case (kind)
                    0: repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                    1: send_queue(1'b1, $urandom_range(1, hdr_q.size() - 1));
                    2: send_queue(1'b0, hdr_q.size());
                    default: send_queue(1'b1, hdr_q.size());
                endcase
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d header bytes, %0d status items (%0d complete, %0d invalid)",
                 sent, checked, n_complete, n_invalid);
        $display("across %0d length limit writes with random gaps and stalls on both sides",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("pipe_delimited_header_parser_core test passed");
        end else begin
            $display("pipe_delimited_header_parser_core test failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/hpp_pkg.sv
hw/rtl/hpp_in_stage.sv
hw/rtl/hpp_parse_core.sv
hw/rtl/hpp_out_stage.sv
hw/rtl/pipe_delimited_header_parser_core.sv
hw/rtl/hpp_checker.sv
dv/header_status_checker.sv
dv/pipe_delimited_header_parser_core_tb.sv
